/* design/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ACT_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define ACT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

/* design/act_pkg.sv */
`default_nettype none
package act_pkg;

   localparam int MAX_IDENTITIES_DEF = 64;
   localparam int MAX_GRANTS_DEF     = 256;

   localparam int ID_ENTRY_W = 20;
   localparam int GR_ENTRY_W = 35;

   localparam logic [2:0] FUNC_CREATE = 3'd0;
   localparam logic [2:0] FUNC_DELETE = 3'd1;
   localparam logic [2:0] FUNC_ENABLE = 3'd2;
   localparam logic [2:0] FUNC_GRANT  = 3'd3;
   localparam logic [2:0] FUNC_REVOKE = 3'd4;
   localparam logic [2:0] FUNC_CHECK  = 3'd5;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_FULL      = 2'd1;
   localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

   typedef struct packed {
      logic [2:0]  func;
      logic [15:0] identity_number;
      logic [15:0] point_number;
      logic [2:0]  grant_level;
      logic [2:0]  required_level;
      logic [2:0]  identity_kind;
      logic        enable_flag;
   } req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [15:0] new_identity_number;
      logic [2:0]  granted_level;
      logic        access_ok;
      logic [6:0]  identities_held;
      logic [8:0]  grants_held;
   } rsp_type;

endpackage
`default_nettype wire

/* design/act_ram.sv */
`default_nettype none
module act_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

/* design/access_control_table.sv */
// Access control table. A request transfers when start is high and busy is low.
// Busy then stays high through the identity sweep, the grant sweep and the
// completion step. It drops in the cycle the single result is shown.
// The time is set by two sweeps through memories with one write port and one
// registered read port. First the identity memory is read one entry per cycle,
// then the grant memory is read the same way. A final completion step decides
// the answer and writes back.
// The result on rsp_item is marked by rsp_strobe, which is high for exactly one
// cycle. The receiver cannot stall it, so it must take every result as it comes.
// A new request may be started in the cycle the result is shown.
`default_nettype none
`include "assert_macros.svh"
module access_control_table #(
   parameter int MAX_IDENTITIES = act_pkg::MAX_IDENTITIES_DEF,
   parameter int MAX_GRANTS     = act_pkg::MAX_GRANTS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output logic                   busy,
   input  wire act_pkg::req_type  req_item,
   output logic                   rsp_strobe,
   output act_pkg::rsp_type       rsp_item
);

   // index and counter widths
   localparam int IW  = (MAX_IDENTITIES > 1) ? $clog2(MAX_IDENTITIES) : 1;
   localparam int ICW = $clog2(MAX_IDENTITIES + 1);
   localparam int GW  = (MAX_GRANTS > 1) ? $clog2(MAX_GRANTS) : 1;
   localparam int GCW = $clog2(MAX_GRANTS + 1);

   // sequencer states
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_IDS  = 2'd1;
   localparam logic [1:0] S_GRS  = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]                state_ff, state_in;
   act_pkg::req_type          req_ff;
   logic [ICW-1:0]            icnt_ff, icnt_in;
   logic [GCW-1:0]            gcnt_ff, gcnt_in;
   logic [MAX_IDENTITIES-1:0] idv_ff;
   logic [MAX_GRANTS-1:0]     gv_ff;
   logic [ICW-1:0]            id_total_ff;
   logic [GCW-1:0]            gr_total_ff;
   logic [16:0]               next_num_ff;

   // scan findings
   logic                      id_hit_ff;
   logic [IW-1:0]             id_slot_ff;
   logic [act_pkg::ID_ENTRY_W-1:0] id_entry_ff;
   logic                      id_free_ff;
   logic [IW-1:0]             id_free_slot_ff;
   logic                      gr_hit_ff;
   logic [GW-1:0]             gr_slot_ff;
   logic                      gr_free_ff;
   logic [GW-1:0]             gr_free_slot_ff;
   logic [2:0]                lvl_max_ff;

   logic                      rsp_strobe_ff;
   act_pkg::rsp_type          rsp_ff;

   // memory ports
   logic [IW-1:0]                  id_rd_addr;
   logic [act_pkg::ID_ENTRY_W-1:0] id_rd_data;
   logic                           id_we;
   logic [IW-1:0]                  id_waddr;
   logic [act_pkg::ID_ENTRY_W-1:0] id_wdata;
   logic [GW-1:0]                  gr_rd_addr;
   logic [act_pkg::GR_ENTRY_W-1:0] gr_rd_data;
   logic                           gr_we;
   logic [GW-1:0]                  gr_waddr;
   logic [act_pkg::GR_ENTRY_W-1:0] gr_wdata;

   // scan position of the data now coming out of the memories
   logic [ICW-1:0] id_pos;
   logic [IW-1:0]  id_idx;
   logic [GCW-1:0] gr_pos;
   logic [GW-1:0]  gr_idx;
   logic           id_data_ok;
   logic           gr_data_ok;
   logic           id_match;
   logic           gr_match;
   logic           gr_owner;

   // completion results
   logic [1:0]     done_status;
   logic [15:0]    done_newnum;
   logic [2:0]     done_lvl;
   logic           done_ok;
   logic [ICW-1:0] id_total_in;
   logic [GCW-1:0] gr_total_in;
   logic [16:0]    next_num_in;
   logic           idv_set, idv_clr, gv_set, gv_clr;

   act_ram #(.WIDTH(act_pkg::ID_ENTRY_W), .DEPTH(MAX_IDENTITIES)) u_id_ram (
      .clock   (clock),
      .wr_en   (id_we),
      .wr_addr (id_waddr),
      .wr_data (id_wdata),
      .rd_addr (id_rd_addr),
      .rd_data (id_rd_data)
   );

   act_ram #(.WIDTH(act_pkg::GR_ENTRY_W), .DEPTH(MAX_GRANTS)) u_gr_ram (
      .clock   (clock),
      .wr_en   (gr_we),
      .wr_addr (gr_waddr),
      .wr_data (gr_wdata),
      .rd_addr (gr_rd_addr),
      .rd_data (gr_rd_data)
   );

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_ff;

   // read address leads the processed index, as the memory read is registered
   assign id_rd_addr = (icnt_ff < ICW'(MAX_IDENTITIES)) ? icnt_ff[IW-1:0] : '0;
   assign gr_rd_addr = (gcnt_ff < GCW'(MAX_GRANTS)) ? gcnt_ff[GW-1:0] : '0;
   assign id_pos     = icnt_ff - ICW'(1);
   assign id_idx     = id_pos[IW-1:0];
   assign gr_pos     = gcnt_ff - GCW'(1);
   assign gr_idx     = gr_pos[GW-1:0];
   assign id_data_ok = (state_ff == S_IDS) && (icnt_ff != '0);
   assign gr_data_ok = (state_ff == S_GRS) && (gcnt_ff != '0);

   assign id_match = idv_ff[id_idx] && (id_rd_data[15:0] == req_ff.identity_number);
   assign gr_match = gv_ff[gr_idx] && (gr_rd_data[15:0] == req_ff.identity_number)
                     && (gr_rd_data[31:16] == req_ff.point_number);
   // grant owned by the identity being deleted
   assign gr_owner = gv_ff[gr_idx] && (gr_rd_data[15:0] == req_ff.identity_number)
                     && (req_ff.func == act_pkg::FUNC_DELETE) && id_hit_ff;

   // sequencer
   always_comb begin
      state_in = state_ff;
      icnt_in  = icnt_ff;
      gcnt_in  = gcnt_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               state_in = S_IDS;
               icnt_in  = '0;
            end
         end
         S_IDS: begin
            if (icnt_ff == ICW'(MAX_IDENTITIES)) begin
               state_in = S_GRS;
               gcnt_in  = '0;
            end else begin
               icnt_in = icnt_ff + ICW'(1);
            end
         end
         S_GRS: begin
            if (gcnt_ff == GCW'(MAX_GRANTS)) begin
               state_in = S_DONE;
            end else begin
               gcnt_in = gcnt_ff + GCW'(1);
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // completion: decide the answer and the write-back
   always_comb begin
      done_status = act_pkg::STATUS_OK;
      done_newnum = '0;
      done_lvl    = '0;
      done_ok     = 1'b0;
      id_total_in = id_total_ff;
      gr_total_in = gr_total_ff;
      next_num_in = next_num_ff;
      idv_set     = 1'b0;
      idv_clr     = 1'b0;
      gv_set      = 1'b0;
      gv_clr      = 1'b0;
      id_we       = 1'b0;
      id_waddr    = id_slot_ff;
      id_wdata    = id_entry_ff;
      gr_we       = 1'b0;
      gr_waddr    = gr_slot_ff;
      gr_wdata    = {req_ff.grant_level, req_ff.point_number, req_ff.identity_number};
      if (state_ff == S_DONE) begin
         case (req_ff.func)
            act_pkg::FUNC_CREATE: begin
               if ((id_total_ff >= ICW'(MAX_IDENTITIES)) || next_num_ff[16] || !id_free_ff) begin
                  done_status = act_pkg::STATUS_FULL;
               end else begin
                  id_we       = 1'b1;
                  id_waddr    = id_free_slot_ff;
                  id_wdata    = {1'b1, req_ff.identity_kind, next_num_ff[15:0]};
                  idv_set     = 1'b1;
                  done_newnum = next_num_ff[15:0];
                  next_num_in = next_num_ff + 17'd1;
                  id_total_in = id_total_ff + ICW'(1);
               end
            end
            act_pkg::FUNC_DELETE: begin
               if (!id_hit_ff) begin
                  done_status = act_pkg::STATUS_NOT_FOUND;
               end else begin
                  idv_clr     = 1'b1;
                  id_total_in = id_total_ff - ICW'(1);
               end
            end
            act_pkg::FUNC_ENABLE: begin
               if (!id_hit_ff) begin
                  done_status = act_pkg::STATUS_NOT_FOUND;
               end else begin
                  id_we    = 1'b1;
                  id_wdata = {req_ff.enable_flag, id_entry_ff[18:0]};
               end
            end
            act_pkg::FUNC_GRANT: begin
               if (gr_total_ff >= GCW'(MAX_GRANTS)) begin
                  done_status = act_pkg::STATUS_FULL;
               end else if (gr_hit_ff) begin
                  gr_we = 1'b1;
               end else if (gr_free_ff) begin
                  gr_we       = 1'b1;
                  gr_waddr    = gr_free_slot_ff;
                  gv_set      = 1'b1;
                  gr_total_in = gr_total_ff + GCW'(1);
               end else begin
                  done_status = act_pkg::STATUS_FULL;
               end
            end
            act_pkg::FUNC_REVOKE: begin
               if (!gr_hit_ff) begin
                  done_status = act_pkg::STATUS_NOT_FOUND;
               end else begin
                  gv_clr      = 1'b1;
                  gr_total_in = gr_total_ff - GCW'(1);
               end
            end
            act_pkg::FUNC_CHECK: begin
               // disabled or unknown identity counts as level zero
               done_lvl = (id_hit_ff && id_entry_ff[19]) ? lvl_max_ff : 3'd0;
               done_ok  = (done_lvl >= req_ff.required_level);
            end
            default: begin
               done_status = act_pkg::STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         icnt_ff       <= '0;
         gcnt_ff       <= '0;
         idv_ff        <= '0;
         gv_ff         <= '0;
         id_total_ff   <= '0;
         gr_total_ff   <= '0;
         next_num_ff   <= 17'd1;
         rsp_strobe_ff <= 1'b0;
         id_hit_ff     <= 1'b0;
         id_free_ff    <= 1'b0;
         gr_hit_ff     <= 1'b0;
         gr_free_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         icnt_ff       <= icnt_in;
         gcnt_ff       <= gcnt_in;
         rsp_strobe_ff <= (state_ff == S_DONE);
         next_num_ff   <= next_num_in;
         id_total_ff   <= id_total_in;
         if ((state_ff == S_IDLE) && start) begin
            id_hit_ff  <= 1'b0;
            id_free_ff <= 1'b0;
            gr_hit_ff  <= 1'b0;
            gr_free_ff <= 1'b0;
         end
         // identity sweep: first match and first free slot
         if (id_data_ok) begin
            if (id_match && !id_hit_ff) begin
               id_hit_ff <= 1'b1;
            end
            if (!idv_ff[id_idx] && !id_free_ff) begin
               id_free_ff <= 1'b1;
            end
         end
         // grant sweep: pair match, free slot, cascade removal on delete
         if (gr_data_ok) begin
            if (gr_match && !gr_hit_ff) begin
               gr_hit_ff <= 1'b1;
            end
            if (!gv_ff[gr_idx] && !gr_free_ff) begin
               gr_free_ff <= 1'b1;
            end
            if (gr_owner) begin
               gv_ff[gr_idx] <= 1'b0;
            end
         end
         if (gr_data_ok && gr_owner) begin
            gr_total_ff <= gr_total_ff - GCW'(1);
         end else begin
            gr_total_ff <= gr_total_in;
         end
         if (idv_set) begin
            idv_ff[id_free_slot_ff] <= 1'b1;
         end
         if (idv_clr) begin
            idv_ff[id_slot_ff] <= 1'b0;
         end
         if (gv_set) begin
            gv_ff[gr_free_slot_ff] <= 1'b1;
         end
         if (gv_clr) begin
            gv_ff[gr_slot_ff] <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if ((state_ff == S_IDLE) && start) begin
         req_ff     <= req_item;
         lvl_max_ff <= '0;
      end
      if (id_data_ok) begin
         if (id_match && !id_hit_ff) begin
            id_slot_ff  <= id_idx;
            id_entry_ff <= id_rd_data;
         end
         if (!idv_ff[id_idx] && !id_free_ff) begin
            id_free_slot_ff <= id_idx;
         end
      end
      if (gr_data_ok) begin
         if (gr_match && !gr_hit_ff) begin
            gr_slot_ff <= gr_idx;
         end
         if (gr_match && (gr_rd_data[34:32] > lvl_max_ff)) begin
            lvl_max_ff <= gr_rd_data[34:32];
         end
         if (!gv_ff[gr_idx] && !gr_free_ff) begin
            gr_free_slot_ff <= gr_idx;
         end
      end
      if (state_ff == S_DONE) begin
         rsp_ff.status              <= done_status;
         rsp_ff.new_identity_number <= done_newnum;
         rsp_ff.granted_level       <= done_lvl;
         rsp_ff.access_ok           <= done_ok;
         rsp_ff.identities_held     <= 7'(id_total_in);
         rsp_ff.grants_held         <= 9'(gr_total_in);
      end
   end

   // a result follows only the completion step of an accepted request
   `ACT_ASSERT(a_strobe_after_busy, !rsp_strobe_ff || $past(state_ff == S_DONE), "result without completion")
   // one result per request
   `ACT_ASSERT_NEXT(a_single_result, rsp_strobe_ff, !rsp_strobe_ff, "result repeated")
   // counts stay within the table sizes
   `ACT_ASSERT(a_id_bound, id_total_ff <= ICW'(MAX_IDENTITIES), "identity count overflow")
   `ACT_ASSERT(a_gr_bound, gr_total_ff <= GCW'(MAX_GRANTS), "grant count overflow")
   // a transfer starts the identity sweep
   `ACT_ASSERT_NEXT(a_start_sweep, start && !busy, state_ff == S_IDS && icnt_ff == '0, "sweep not started")

endmodule
`default_nettype wire
